### src/lce_pkg.sv
// shared types for the lehmer code encoder
`default_nettype none
package lce_pkg;

	localparam int unsigned ValW   = 4;
	localparam int unsigned DigitW = 4;
	localparam int unsigned CfgW   = 5;

	// word as it moves down the cell row
	typedef struct packed {
		logic [ValW-1:0]   val;
		logic [DigitW-1:0] count;
		logic              bad;
		logic              last;
	} word_t;

endpackage : lce_pkg
`default_nettype wire

### src/lce_cell.sv
// one cell of the row: holds one used bit and one word in flight
`default_nettype none
module lce_cell #(
	parameter int unsigned IDX = 0
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                up_valid,
	input  wire lce_pkg::word_t up_word,
	output logic               up_free,
	output logic               dn_valid,
	output lce_pkg::word_t     dn_word,
	input  wire                dn_free
);

	localparam logic [lce_pkg::ValW-1:0] MyVal = lce_pkg::ValW'(IDX);

	logic           valid_q;
	lce_pkg::word_t word_q;
	logic           used_q;
	logic           adv;
	logic           hit;
	logic           below;

	assign adv     = valid_q && dn_free;
	assign up_free = !valid_q || adv;

	assign hit   = !word_q.bad && (word_q.val == MyVal);
	assign below = (word_q.val > MyVal) && !used_q;

	always_comb begin
		dn_word       = word_q;
		dn_word.bad   = word_q.bad || (hit && used_q);
		dn_word.count = word_q.count + lce_pkg::DigitW'(below);
	end
	assign dn_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			used_q  <= 1'b0;
		end else begin
			if (up_free) begin
				valid_q <= up_valid;
			end
			// bit changes as the word leaves, so the next word sees it
			if (adv) begin
				used_q <= word_q.last ? 1'b0 : (used_q || hit);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_free && up_valid) begin
			word_q <= up_word;
		end
	end

endmodule : lce_cell
`default_nettype wire

### src/lehmer_code_encoder.sv
// lehmer code encoder top level: entry logic, cell row and output register
//
// channel   direction  handshake                   payload
// in        input      in_valid / in_stall         element_value
// out       output     out_valid / out_stall       lehmer_digit, last_of_perm, bad_element
// cfg       input      cfg_valid / cfg_ready       perm_length
//
// one word accepted every cycle while in_stall is low; each word walks the row of cells, one cell a
// cycle unless held, and then passes through the output register
// cell i holds used bit i and updates it as a word leaves, keeping words in order
// arst_n clears valid flags, used bits, position; perm_length resets to 16
// a stalled output holds; words collapse into empty cells, input stalls only
// when every cell and the output register are full
`default_nettype none
module lehmer_code_encoder #(
	parameter int unsigned MAX_LEN = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  [lce_pkg::ValW-1:0]      element_value,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic [lce_pkg::DigitW-1:0]    lehmer_digit,
	output logic                          last_of_perm,
	output logic                          bad_element,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [lce_pkg::CfgW-1:0]      perm_length
);

	// cells only for values an element can name
	localparam int unsigned NumVals = (MAX_LEN < (1 << lce_pkg::ValW)) ?
		MAX_LEN : (1 << lce_pkg::ValW);
	localparam int unsigned LenW  = $clog2(MAX_LEN + 1);
	localparam int unsigned CmpW  = (LenW > lce_pkg::CfgW) ? LenW : lce_pkg::CfgW;
	localparam int unsigned PosW  = $clog2(MAX_LEN);
	localparam logic [CmpW-1:0] MaxLen = CmpW'(MAX_LEN);

	logic [lce_pkg::CfgW-1:0] perm_length_q;
	logic [PosW-1:0]          pos_q;
	logic [CmpW-1:0]          len_raw;
	logic [CmpW-1:0]          len_eff;
	logic [CmpW:0]            pos_next;
	logic                     entry_last;
	logic                     accept;
	lce_pkg::word_t           entry_word;

	logic                     valid_c [0:NumVals];
	lce_pkg::word_t           word_c  [0:NumVals];
	logic                     free_c  [0:NumVals];

	logic                     out_valid_q;
	lce_pkg::word_t           out_word_q;
	logic                     out_free;

	// config register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_length_q <= lce_pkg::CfgW'(16);
		end else if (cfg_valid) begin
			perm_length_q <= perm_length;
		end
	end

	// clamp length into 1..MAX_LEN
	assign len_raw = CmpW'(perm_length_q);
	always_comb begin
		priority if (len_raw == '0) begin
			len_eff = CmpW'(1);
		end else if (len_raw > MaxLen) begin
			len_eff = MaxLen;
		end else begin
			len_eff = len_raw;
		end
	end

	// entry: range check and end-of-permutation decision
	assign accept     = in_valid && !in_stall;
	assign pos_next   = (CmpW + 1)'(pos_q) + (CmpW + 1)'(1);
	assign entry_last = pos_next >= {1'b0, len_eff};

	always_comb begin
		entry_word.val   = element_value;
		entry_word.count = '0;
		entry_word.bad   = CmpW'(element_value) >= len_eff;
		entry_word.last  = entry_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= entry_last ? '0 : PosW'(pos_next);
		end
	end

	// row of cells
	assign valid_c[0] = in_valid;
	assign word_c[0]  = entry_word;
	assign in_stall   = !free_c[0];

	for (genvar i = 0; i < NumVals; i++) begin : g_cell
		lce_cell #(
			.IDX(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_valid(valid_c[i]),
			.up_word (word_c[i]),
			.up_free (free_c[i]),
			.dn_valid(valid_c[i+1]),
			.dn_word (word_c[i+1]),
			.dn_free (free_c[i+1])
		);
	end

	// output register
	assign out_free         = !out_valid_q || !out_stall;
	assign free_c[NumVals]  = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_c[NumVals];
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_c[NumVals]) begin
			out_word_q <= word_c[NumVals];
		end
	end

	assign out_valid    = out_valid_q;
	assign lehmer_digit = out_word_q.bad ? '0 : out_word_q.count;
	assign last_of_perm = out_word_q.last;
	assign bad_element  = out_word_q.bad;

	// input blocks only behind a held output word
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall && valid_c[1]))
		else $error("input stalled without a held output word");

	// a final word restarts the position count
	a_last_resets_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && entry_last) |=> (pos_q == '0))
		else $error("position not cleared after final word");

	// a stalled output word stays valid and unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable({lehmer_digit, last_of_perm, bad_element})))
		else $error("stalled output word changed");

endmodule : lehmer_code_encoder
`default_nettype wire
